FILE: rtl/rectangle_clip_unit_top_assert.svh
// Assertion macros shared by the rectangle clip unit checker
`ifndef RECTANGLE_CLIP_UNIT_TOP_ASSERT_SVH
`define RECTANGLE_CLIP_UNIT_TOP_ASSERT_SVH

// Same-cycle implication, ignored while reset is high
`define RCU_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high
`define RCU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/rcu_pkg.sv
// Package for the rectangle clip unit: operation codes, sizes and control types
`default_nettype none

package rcu_pkg;

  // Default coordinate width
  localparam int COORD_WIDTH_DEF = 16;

  // Pieces per item and edges per piece
  localparam int NUM_PIECES = 4;
  localparam int NUM_EDGES  = 4;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Edge slots within one piece
  localparam int EDGE_L = 0;
  localparam int EDGE_T = 1;
  localparam int EDGE_R = 2;
  localparam int EDGE_B = 3;

  // Operation codes
  localparam logic [2:0] KIND_INTERSECTS    = 3'd0;
  localparam logic [2:0] KIND_INTERSECTION  = 3'd1;
  localparam logic [2:0] KIND_SUBTRACT      = 3'd2;
  localparam logic [2:0] KIND_CONTAINS_RECT = 3'd3;
  localparam logic [2:0] KIND_CONTAINS_PT   = 3'd4;

  // Per-item control carried through the queue
  typedef struct packed {
    logic                  flag;
    logic [NUM_PIECES-1:0] mask;
  } rcu_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/rcu_front.sv
// Front end: forms edges, classifies the operation and builds the pieces to emit
`default_nettype none

module rcu_front #(
  parameter int CW = rcu_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                  valid,
  output logic                       stall,
  input  wire logic [2:0]            kind,
  input  wire logic signed [CW-1:0]  a_left,
  input  wire logic signed [CW-1:0]  a_top,
  input  wire logic [CW-2:0]         a_width,
  input  wire logic [CW-2:0]         a_height,
  input  wire logic signed [CW-1:0]  b_left,
  input  wire logic signed [CW-1:0]  b_top,
  input  wire logic [CW-2:0]         b_width,
  input  wire logic [CW-2:0]         b_height,
  input  wire logic signed [CW-1:0]  point_x,
  input  wire logic signed [CW-1:0]  point_y,
  input  wire logic                  queue_full,
  output logic                       wr_en,
  output rcu_pkg::rcu_ctl_t          wr_ctl,
  output logic [rcu_pkg::NUM_PIECES-1:0][rcu_pkg::NUM_EDGES-1:0][CW:0] wr_pieces
);
  import rcu_pkg::*;

  localparam int EW = CW + 1;

  logic signed [EW-1:0] al, at, bl, bt, px, py;
  logic signed [EW-1:0] ar, ab, br, bb;
  logic signed [EW-1:0] max_l, max_t, min_r, min_b;
  logic                 hit, in_rect, in_pt;

  // Edges one bit wider than a coordinate
  assign al = {a_left[CW-1], a_left};
  assign at = {a_top[CW-1], a_top};
  assign bl = {b_left[CW-1], b_left};
  assign bt = {b_top[CW-1], b_top};
  assign px = {point_x[CW-1], point_x};
  assign py = {point_y[CW-1], point_y};
  assign ar = al + $signed({2'b00, a_width});
  assign ab = at + $signed({2'b00, a_height});
  assign br = bl + $signed({2'b00, b_width});
  assign bb = bt + $signed({2'b00, b_height});

  // Overlap and containment tests
  assign hit     = !(bb <= at || br <= al || ar <= bl || ab <= bt);
  assign in_rect = (al <= bl) && (br <= ar) && (at <= bt) && (bb <= ab);
  assign in_pt   = (al <= px) && (px < ar) && (at <= py) && (py < ab);

  // Overlap window
  assign max_l = (al > bl) ? al : bl;
  assign max_t = (at > bt) ? at : bt;
  assign min_r = (ar < br) ? ar : br;
  assign min_b = (ab < bb) ? ab : bb;

  // Operation decode: which pieces exist and their edges
  always_comb begin
    wr_ctl    = '0;
    wr_pieces = '0;
    unique case (kind)
      KIND_INTERSECTS: begin
        wr_ctl.flag = hit;
        wr_ctl.mask = NUM_PIECES'(1);
      end
      KIND_INTERSECTION: begin
        wr_ctl.mask             = NUM_PIECES'(1);
        wr_pieces[0][EDGE_L]    = max_l;
        wr_pieces[0][EDGE_T]    = max_t;
        wr_pieces[0][EDGE_R]    = min_r;
        wr_pieces[0][EDGE_B]    = min_b;
      end
      KIND_SUBTRACT: begin
        if (hit) begin
          wr_ctl.mask = {bb < ab, br < ar, al < bl, at < bt};
          // above B
          wr_pieces[0][EDGE_L] = max_l;
          wr_pieces[0][EDGE_T] = at;
          wr_pieces[0][EDGE_R] = min_r;
          wr_pieces[0][EDGE_B] = bt;
          // left of B
          wr_pieces[1][EDGE_L] = al;
          wr_pieces[1][EDGE_T] = at;
          wr_pieces[1][EDGE_R] = bl;
          wr_pieces[1][EDGE_B] = ab;
          // right of B
          wr_pieces[2][EDGE_L] = br;
          wr_pieces[2][EDGE_T] = at;
          wr_pieces[2][EDGE_R] = ar;
          wr_pieces[2][EDGE_B] = ab;
          // below B
          wr_pieces[3][EDGE_L] = max_l;
          wr_pieces[3][EDGE_T] = min_b;
          wr_pieces[3][EDGE_R] = min_r;
          wr_pieces[3][EDGE_B] = ab;
        end else begin
          wr_ctl.mask          = NUM_PIECES'(1);
          wr_pieces[0][EDGE_L] = al;
          wr_pieces[0][EDGE_T] = at;
          wr_pieces[0][EDGE_R] = ar;
          wr_pieces[0][EDGE_B] = ab;
        end
      end
      KIND_CONTAINS_RECT: begin
        wr_ctl.flag = in_rect;
        wr_ctl.mask = NUM_PIECES'(1);
      end
      KIND_CONTAINS_PT: begin
        wr_ctl.flag = in_pt;
        wr_ctl.mask = NUM_PIECES'(1);
      end
      default: begin
        wr_ctl = '0;
      end
    endcase
  end

  // Beats with nothing to emit are taken and dropped
  assign stall = queue_full;
  assign wr_en = valid && !queue_full && (wr_ctl.mask != '0);

endmodule

`default_nettype wire

FILE: rtl/rcu_queue.sv
// Short queue of classified items between front and back
`default_nettype none

module rcu_queue #(
  parameter int CW = rcu_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire rcu_pkg::rcu_ctl_t   wr_ctl,
  input  wire logic [rcu_pkg::NUM_PIECES-1:0][rcu_pkg::NUM_EDGES-1:0][CW:0] wr_pieces,
  output logic                     full,
  output logic                     rd_valid,
  output rcu_pkg::rcu_ctl_t        rd_ctl,
  output logic [rcu_pkg::NUM_PIECES-1:0][rcu_pkg::NUM_EDGES-1:0][CW:0] rd_pieces,
  input  wire logic                pop
);
  import rcu_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  rcu_ctl_t                                  ctl_q   [QUEUE_DEPTH];
  logic [NUM_PIECES-1:0][NUM_EDGES-1:0][CW:0] piece_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]                          wr_ptr, rd_ptr;
  logic [CNT_W-1:0]                          count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_ctl   = ctl_q[rd_ptr];
  assign rd_pieces = piece_q[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ctl_q[wr_ptr]   <= wr_ctl;
      piece_q[wr_ptr] <= wr_pieces;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rcu_back.sv
// Back end: walks the pieces of the head item, folds and saturates, drives result beats
`default_nettype none

module rcu_back #(
  parameter int CW = rcu_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                rd_valid,
  input  wire rcu_pkg::rcu_ctl_t   rd_ctl,
  input  wire logic [rcu_pkg::NUM_PIECES-1:0][rcu_pkg::NUM_EDGES-1:0][CW:0] rd_pieces,
  output logic                     pop,
  output logic                     valid,
  input  wire logic                stall,
  output logic                     flag,
  output logic signed [CW-1:0]     res_left,
  output logic signed [CW-1:0]     res_top,
  output logic [CW-2:0]            res_width,
  output logic [CW-2:0]            res_height,
  output logic                     last
);
  import rcu_pkg::*;

  localparam int EW      = CW + 1;
  localparam int DW      = CW + 2;
  localparam int PIECE_W = $clog2(NUM_PIECES);

  // Saturate a wide edge to the signed coordinate range
  function automatic logic [CW-1:0] sat_coord(input logic [EW-1:0] v);
    logic [CW-1:0] r;
    if (v[EW-1] != v[EW-2]) begin
      r = v[EW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  // Saturate a non-negative size to the size range
  function automatic logic [CW-2:0] sat_size(input logic [DW-1:0] v);
    logic [CW-2:0] r;
    if (|v[DW-1:CW-1]) begin
      r = {(CW-1){1'b1}};
    end else begin
      r = v[CW-2:0];
    end
    return r;
  endfunction

  logic [NUM_PIECES-1:0] done;
  logic [NUM_PIECES-1:0] remaining, sel_hot, rest;
  logic [PIECE_W-1:0]    sel;
  logic                  found, is_last, load;
  logic [EW-1:0]         pl, pt, pr, pb, lo_x, lo_y;
  logic [DW-1:0]         dx_pos, dx_neg, dy_pos, dy_neg, mag_x, mag_y;

  // Pick the lowest piece still to go
  assign remaining = rd_ctl.mask & ~done;
  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int i = 0; i < NUM_PIECES; i++) begin
      if (remaining[i] && !found) begin
        sel   = PIECE_W'(i);
        found = 1'b1;
      end
    end
  end
  assign sel_hot = NUM_PIECES'(1) << sel;
  assign rest    = remaining & ~sel_hot;
  assign is_last = (rest == '0);

  // Output register free or being drained
  assign load = rd_valid && (!valid || !stall);
  assign pop  = load && is_last;

  // Fold a negative size back onto the edge
  assign pl     = rd_pieces[sel][EDGE_L];
  assign pt     = rd_pieces[sel][EDGE_T];
  assign pr     = rd_pieces[sel][EDGE_R];
  assign pb     = rd_pieces[sel][EDGE_B];
  assign dx_pos = {pr[EW-1], pr} - {pl[EW-1], pl};
  assign dx_neg = {pl[EW-1], pl} - {pr[EW-1], pr};
  assign dy_pos = {pb[EW-1], pb} - {pt[EW-1], pt};
  assign dy_neg = {pt[EW-1], pt} - {pb[EW-1], pb};
  assign lo_x   = dx_pos[DW-1] ? pr : pl;
  assign mag_x  = dx_pos[DW-1] ? dx_neg : dx_pos;
  assign lo_y   = dy_pos[DW-1] ? pb : pt;
  assign mag_y  = dy_pos[DW-1] ? dy_neg : dy_pos;

  // Progress through the head item
  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= '0;
      valid <= 1'b0;
    end else begin
      if (load) begin
        done <= is_last ? '0 : (done | sel_hot);
      end
      if (!valid || !stall) begin
        valid <= rd_valid;
      end
    end
  end

  // Result beat
  always_ff @(posedge clk) begin
    if (load) begin
      flag       <= rd_ctl.flag;
      res_left   <= sat_coord(lo_x);
      res_top    <= sat_coord(lo_y);
      res_width  <= sat_size(mag_x);
      res_height <= sat_size(mag_y);
      last       <= is_last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rectangle_clip_unit_top.sv
// Top level of the rectangle clip unit
//
// Request channel (req_valid / req_stall): one beat carries an operation kind,
// rectangles A and B and a test point. Result channel (res_valid / res_stall):
// one beat carries a flag and a rectangle; last marks the final beat of a request.
// Flag kinds and intersection give one beat, subtract gives up to four, or none
// when A is fully covered; unused kind codes are taken and give nothing.
// A taken request is written into the queue, and the back end loads the output
// register from the queue head whenever that register is free or being drained.
// Throughput: one result beat per cycle while res_stall is low, set by the back
// end emitting one piece a cycle; requests giving one beat each are taken back to
// back. A two-entry queue sits between front and back; req_stall rises only when
// it is full, e.g. while a subtract drains its pieces.
// When res_stall is high the result beat holds and the back end waits; the
// front keeps taking requests until the queue fills.
// Reset (rst, synchronous) empties the queue and drops any result beat.
`default_nettype none

module rectangle_clip_unit_top #(
  parameter int COORD_WIDTH = rcu_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire logic [2:0]                    kind,
  input  wire logic signed [COORD_WIDTH-1:0] a_left,
  input  wire logic signed [COORD_WIDTH-1:0] a_top,
  input  wire logic [COORD_WIDTH-2:0]        a_width,
  input  wire logic [COORD_WIDTH-2:0]        a_height,
  input  wire logic signed [COORD_WIDTH-1:0] b_left,
  input  wire logic signed [COORD_WIDTH-1:0] b_top,
  input  wire logic [COORD_WIDTH-2:0]        b_width,
  input  wire logic [COORD_WIDTH-2:0]        b_height,
  input  wire logic signed [COORD_WIDTH-1:0] point_x,
  input  wire logic signed [COORD_WIDTH-1:0] point_y,
  output logic                               res_valid,
  input  wire logic                          res_stall,
  output logic                               flag,
  output logic signed [COORD_WIDTH-1:0]      res_left,
  output logic signed [COORD_WIDTH-1:0]      res_top,
  output logic [COORD_WIDTH-2:0]             res_width,
  output logic [COORD_WIDTH-2:0]             res_height,
  output logic                               last
);
  import rcu_pkg::*;

  logic                                               wr_en, queue_full;
  logic                                               rd_valid, pop;
  rcu_ctl_t                                           wr_ctl, rd_ctl;
  logic [NUM_PIECES-1:0][NUM_EDGES-1:0][COORD_WIDTH:0] wr_pieces, rd_pieces;

  rcu_front #(.CW(COORD_WIDTH)) u_front (
    .valid      (req_valid),
    .stall      (req_stall),
    .kind       (kind),
    .a_left     (a_left),
    .a_top      (a_top),
    .a_width    (a_width),
    .a_height   (a_height),
    .b_left     (b_left),
    .b_top      (b_top),
    .b_width    (b_width),
    .b_height   (b_height),
    .point_x    (point_x),
    .point_y    (point_y),
    .queue_full (queue_full),
    .wr_en      (wr_en),
    .wr_ctl     (wr_ctl),
    .wr_pieces  (wr_pieces)
  );

  rcu_queue #(.CW(COORD_WIDTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_ctl    (wr_ctl),
    .wr_pieces (wr_pieces),
    .full      (queue_full),
    .rd_valid  (rd_valid),
    .rd_ctl    (rd_ctl),
    .rd_pieces (rd_pieces),
    .pop       (pop)
  );

  rcu_back #(.CW(COORD_WIDTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .rd_valid   (rd_valid),
    .rd_ctl     (rd_ctl),
    .rd_pieces  (rd_pieces),
    .pop        (pop),
    .valid      (res_valid),
    .stall      (res_stall),
    .flag       (flag),
    .res_left   (res_left),
    .res_top    (res_top),
    .res_width  (res_width),
    .res_height (res_height),
    .last       (last)
  );

endmodule

`default_nettype wire

FILE: rtl/rcu_checker.sv
// Port-level checks on the rectangle clip unit, bound to the top level
`default_nettype none

`include "rectangle_clip_unit_top_assert.svh"

module rcu_checker #(
  parameter int CW = rcu_pkg::COORD_WIDTH_DEF
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 res_valid,
  input wire logic                 res_stall,
  input wire logic                 flag,
  input wire logic signed [CW-1:0] res_left,
  input wire logic signed [CW-1:0] res_top,
  input wire logic [CW-2:0]        res_width,
  input wire logic [CW-2:0]        res_height,
  input wire logic                 last
);

  // A stalled result beat holds
  `RCU_ASSERT_NEXT(a_hold, clk, rst, res_valid && res_stall, res_valid && $stable(flag) && $stable(res_left) && $stable(res_top) && $stable(res_width) && $stable(res_height) && $stable(last), "stalled result beat changed")

  // Beats with the flag set carry an empty rectangle
  `RCU_ASSERT_IMPLY(a_flag_zero, clk, rst, res_valid && flag, res_left == '0 && res_top == '0 && res_width == '0 && res_height == '0, "flag beat with non-zero rectangle")

  // Beats with the flag set are single beats
  `RCU_ASSERT_IMPLY(a_flag_last, clk, rst, res_valid && flag, last, "flag beat not marked last")

  // Pieces of one request follow without a gap
  `RCU_ASSERT_NEXT(a_no_gap, clk, rst, res_valid && !res_stall && !last, res_valid, "gap inside a multi-beat result")

endmodule

bind rectangle_clip_unit_top rcu_checker #(.CW(COORD_WIDTH)) u_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .flag       (flag),
  .res_left   (res_left),
  .res_top    (res_top),
  .res_width  (res_width),
  .res_height (res_height),
  .last       (last)
);

`default_nettype wire
